>>> sv/rmsp_pkg.sv
// Package with the codes and state type of the running median unit.
`timescale 1ns / 1ps
package rmsp_pkg;
  localparam int unsigned ValW = 32;
  localparam int unsigned StW  = 2;
  localparam int unsigned HcW  = 9;

  localparam logic       KIND_INSERT = 1'b0;
  localparam logic       KIND_POP    = 1'b1;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_POP  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;
endpackage

>>> sv/running_median_select_pop_unit.sv
// Running median unit: a sorted store in one RAM that serves inserts and lower-median pops.
//
// The values are kept in ascending signed order in a single-port-read, single-port-write
// RAM with a registered read. One item is worked on at a time. An insert walks down
// from the top cell, shifting larger values up one cell per cycle, or writes straight
// into cell 0 of an empty store; a pop on n held values reads the lower median and
// shifts the cells above it down. A pop on an empty store or an insert into a full
// store goes straight to its result with status EMPTY or FULL. Each cycle moves one
// cell through the RAM ports. Every item gives exactly one result transfer, held in an
// output register so that a new item can be taken while that result waits.
`timescale 1ns / 1ps
module running_median_select_pop_unit
  import rmsp_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] median, [40:32] held_count, rest zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Sorted store.
  logic [ValW-1:0] mem [CAPACITY];
  logic            we, re;
  logic [AW-1:0]   wa, ra;
  logic [ValW-1:0] wd;
  logic [ValW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_q <= mem[ra];
    end
  end

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   rd_cnt_q, rd_cnt_d;
  logic            pend_q, pend_d;
  logic [AW-1:0]   pend_addr_q, pend_addr_d;
  logic [AW-1:0]   pos_q, pos_d;
  logic [ValW-1:0] val_q, val_d;
  logic [ValW-1:0] med_q, med_d;
  logic [StW-1:0]  st_q, st_d;
  logic            ov_q, ov_d;
  logic [ValW-1:0] om_q, om_d;
  logic [StW-1:0]  os_q, os_d;
  logic [HcW-1:0]  oh_q, oh_d;
  logic [CW+HcW-1:0] cnt_ext;
  logic [CW-1:0]   cnt_m1;

  assign cnt_m1  = cnt_q - CW'(1);
  assign cnt_ext = {{HcW{1'b0}}, cnt_q};

  // Sequencer for the shift walks.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_cnt_d    = rd_cnt_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    pos_d       = pos_q;
    val_d       = val_q;
    med_d       = med_q;
    st_d        = st_q;
    we          = 1'b0;
    wa          = '0;
    wd          = '0;
    re          = 1'b0;
    ra          = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          val_d = s_axis_tdata;
          med_d = '0;
          st_d  = ST_OK;
          if (s_axis_tuser == KIND_POP) begin
            if (cnt_q == '0) begin
              st_d    = ST_EMPTY;
              state_d = S_OUT;
            end else begin
              pos_d    = AW'(cnt_m1 >> 1);
              rd_cnt_d = cnt_m1 >> 1;
              state_d  = S_POP;
            end
          end else begin
            if (cnt_q >= CW'(CAPACITY)) begin
              st_d    = ST_FULL;
              state_d = S_OUT;
            end else begin
              rd_cnt_d = cnt_q;
              state_d  = S_INS;
            end
          end
        end
      end
      S_INS: begin
        // Compare the cell read last cycle and shift it up or drop the value in.
        if (pend_q && ($signed(rd_data_q) <= $signed(val_q))) begin
          we      = 1'b1;
          wa      = pend_addr_q + AW'(1);
          wd      = val_q;
          cnt_d   = cnt_q + CW'(1);
          state_d = S_OUT;
        end else if (!pend_q && rd_cnt_q == '0) begin
          we      = 1'b1;
          wa      = '0;
          wd      = val_q;
          cnt_d   = cnt_q + CW'(1);
          state_d = S_OUT;
        end else begin
          if (pend_q) begin
            we = 1'b1;
            wa = pend_addr_q + AW'(1);
            wd = rd_data_q;
          end
          if (rd_cnt_q != '0) begin
            re          = 1'b1;
            ra          = AW'(rd_cnt_q - CW'(1));
            pend_d      = 1'b1;
            pend_addr_d = AW'(rd_cnt_q - CW'(1));
            rd_cnt_d    = rd_cnt_q - CW'(1);
          end
        end
      end
      S_POP: begin
        // Read upward from the median; each cell above it moves down one place.
        if (rd_cnt_q < cnt_q) begin
          re          = 1'b1;
          ra          = AW'(rd_cnt_q);
          pend_d      = 1'b1;
          pend_addr_d = AW'(rd_cnt_q);
          rd_cnt_d    = rd_cnt_q + CW'(1);
        end
        if (pend_q) begin
          if (pend_addr_q == pos_q) begin
            med_d = rd_data_q;
          end else begin
            we = 1'b1;
            wa = pend_addr_q - AW'(1);
            wd = rd_data_q;
          end
          if (pend_addr_q == AW'(cnt_m1)) begin
            pend_d  = 1'b0;
            re      = 1'b0;
            cnt_d   = cnt_m1;
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!ov_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register.
  always_comb begin
    ov_d = ov_q;
    om_d = om_q;
    os_d = os_q;
    oh_d = oh_q;
    if (m_axis_tready) begin
      ov_d = 1'b0;
    end
    if (state_q == S_OUT && (!ov_q || m_axis_tready)) begin
      ov_d = 1'b1;
      om_d = med_q;
      os_d = st_q;
      oh_d = cnt_ext[HcW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      rd_cnt_q <= '0;
      pend_q   <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_cnt_q <= rd_cnt_d;
      pend_q   <= pend_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    pos_q       <= pos_d;
    val_q       <= val_d;
    med_q       <= med_d;
    st_q        <= st_d;
    om_q        <= om_d;
    os_q        <= os_d;
    oh_q        <= oh_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'd0, oh_q, om_q};
  assign m_axis_tuser  = os_q;
endmodule

>>> sv/rmsp_checker.sv
// Port checker for the running median unit, bound to the top level.
`timescale 1ns / 1ps
module rmsp_checker
  import rmsp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  // A held result transfer keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Rejected items carry a zero median.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[31:0] == '0)
    else $error("nonzero median on error status");

  // One item at a time: an accepted item blocks the next cycle's input.
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken in back-to-back cycles");

  // Status never takes the unused code.
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == ST_OK || m_axis_tuser == ST_EMPTY ||
      m_axis_tuser == ST_FULL)
    else $error("bad status code");
endmodule

bind running_median_select_pop_unit rmsp_checker u_rmsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
